[rtl/ems_pkg.sv]
package ems_pkg;

  // field and register widths
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned SUM_W   = 42;
  localparam int unsigned ALPHA_W = 17;
  localparam int unsigned PROD_W  = PRICE_W + ALPHA_W;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = ALPHA_W;

  // default bound on the effective period
  localparam int unsigned MAX_PERIOD_DEF = 1024;

  // register reset values
  localparam logic [CNT_W-1:0]   PERIOD_RST = CNT_W'(14);
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = ALPHA_W'(8738);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(65536);

  // iteration counts of the serial units
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned MUL_STEPS = ALPHA_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // rounding offset for the negative update (floor of a negative shift)
  localparam logic [PROD_W-1:0] RND_NEG = PROD_W'(65535);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD = 1'b0,
    CFG_ALPHA  = 1'b1
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_RND  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

endpackage

[rtl/ema_seeded_by_sma.sv]
// work per sample: a warm-up sample goes straight to the result, the seed sample runs 42
//   bit-serial division steps, a smoothing update 17 bit-serial multiply steps plus round and add
// one request in flight: the next sample is taken only once the last result has entered
//   the output register, which can stall on m_axis_tready
// reset: asynchronous active low; clears series state, average and output valid,
//   period back to 14 and alpha_q to 8738
module ema_seeded_by_sma #(
  parameter int unsigned MAX_PERIOD = ems_pkg::MAX_PERIOD_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input samples
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ems_pkg::PRICE_W-1:0]     s_axis_tdata,  // [31:0] price
  input  logic [0:0]                      s_axis_tuser,  // [0] first
  // results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ems_pkg::PRICE_W-1:0]     m_axis_tdata,  // [31:0] smoothed
  output logic [0:0]                      m_axis_tuser,  // [0] ready_res
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ems_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ems_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned PW = ems_pkg::PRICE_W;
  localparam int unsigned CW = ems_pkg::CNT_W;
  localparam int unsigned SW = ems_pkg::SUM_W;
  localparam int unsigned AW = ems_pkg::ALPHA_W;
  localparam int unsigned MW = ems_pkg::PROD_W;
  localparam int unsigned TW = ems_pkg::STEP_W;

  ems_pkg::state_e state_q, state_d;

  logic [CW-1:0] period_q, period_d;
  logic [AW-1:0] alpha_q_q, alpha_q_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [PW-1:0] avg_q, avg_d;

  logic [SW-1:0] dq_q, dq_d;      // dividend in, quotient out
  logic [CW-1:0] rem_q, rem_d;
  logic [MW-1:0] prod_q, prod_d;  // multiplier in low bits, product builds from top
  logic [PW-1:0] diff_q, diff_d;
  logic          ge_q, ge_d;
  logic [TW-1:0] step_q, step_d;
  logic [PW-1:0] res_data_q, res_data_d;
  logic          res_rdy_q, res_rdy_d;

  logic          out_valid_q, out_valid_d;
  logic [PW-1:0] out_data_q, out_data_d;
  logic          out_user_q, out_user_d;

  logic [CW-1:0] p_eff;
  logic [AW-1:0] a_eff;
  logic          in_req;
  logic [CW-1:0] cnt_base;
  logic [SW-1:0] sum_base;
  logic [SW-1:0] sum_new;
  logic [CW-1:0] cnt_new;
  logic [CW:0]   trial;
  logic          take;
  logic [PW:0]   mul_sum;
  logic [PW-1:0] inc;

  // effective period and smoothing factor
  always_comb begin
    if (period_q == '0) begin
      p_eff = CW'(1);
    end else if (32'(period_q) > 32'(MAX_PERIOD)) begin
      p_eff = CW'(MAX_PERIOD);
    end else begin
      p_eff = period_q;
    end
    a_eff = (alpha_q_q > ems_pkg::ALPHA_ONE) ? ems_pkg::ALPHA_ONE : alpha_q_q;
  end

  assign s_axis_tready = (state_q == ems_pkg::ST_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // series state as seen by the incoming sample
  assign cnt_base = s_axis_tuser[0] ? '0 : cnt_q;
  assign sum_base = s_axis_tuser[0] ? '0 : sum_q;
  assign sum_new  = sum_base + SW'(s_axis_tdata);
  assign cnt_new  = cnt_base + CW'(1);

  // restoring division step
  assign trial = {rem_q, dq_q[SW-1]};
  assign take  = (trial >= {1'b0, p_eff});

  // shift-add multiply step
  assign mul_sum = {1'b0, prod_q[MW-1:AW]} + (prod_q[0] ? {1'b0, diff_q} : '0);
  assign inc     = prod_q[PW+15:16];

  always_comb begin
    state_d     = state_q;
    period_d    = period_q;
    alpha_q_d   = alpha_q_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    avg_d       = avg_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    prod_d      = prod_q;
    diff_d      = diff_q;
    ge_d        = ge_q;
    step_d      = step_q;
    res_data_d  = res_data_q;
    res_rdy_d   = res_rdy_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;

    // configuration writes
    if (cfg_valid_i) begin
      unique case (ems_pkg::cfg_idx_e'(cfg_index_i))
        ems_pkg::CFG_PERIOD: period_d  = cfg_data_i[CW-1:0];
        ems_pkg::CFG_ALPHA:  alpha_q_d = cfg_data_i;
        default: ;
      endcase
    end

    // output register drains independently
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ems_pkg::ST_IDLE: begin
        if (in_req) begin
          step_d = '0;
          if (cnt_base < p_eff) begin
            // warm-up: accumulate, seed when the count reaches the period
            sum_d = sum_new;
            cnt_d = cnt_new;
            if (cnt_new >= p_eff) begin
              dq_d    = sum_new;
              rem_d   = '0;
              state_d = ems_pkg::ST_DIV;
            end else begin
              res_data_d = '0;
              res_rdy_d  = 1'b0;
              state_d    = ems_pkg::ST_DONE;
            end
          end else begin
            // smoothing: multiply alpha by the distance to the price
            cnt_d   = cnt_base;
            sum_d   = sum_base;
            ge_d    = (s_axis_tdata >= avg_q);
            diff_d  = (s_axis_tdata >= avg_q) ? (s_axis_tdata - avg_q)
                                              : (avg_q - s_axis_tdata);
            prod_d  = {{PW{1'b0}}, a_eff};
            state_d = ems_pkg::ST_MUL;
          end
        end
      end
      ems_pkg::ST_DIV: begin
        rem_d  = take ? CW'(trial - {1'b0, p_eff}) : trial[CW-1:0];
        dq_d   = {dq_q[SW-2:0], take};
        step_d = step_q + TW'(1);
        if (step_q == TW'(ems_pkg::DIV_STEPS - 1)) begin
          avg_d      = dq_d[PW-1:0];
          res_data_d = dq_d[PW-1:0];
          res_rdy_d  = 1'b1;
          state_d    = ems_pkg::ST_DONE;
        end
      end
      ems_pkg::ST_MUL: begin
        prod_d = {mul_sum, prod_q[AW-1:1]};
        step_d = step_q + TW'(1);
        if (step_q == TW'(ems_pkg::MUL_STEPS - 1)) begin
          state_d = ems_pkg::ST_RND;
        end
      end
      ems_pkg::ST_RND: begin
        // a negative step rounds toward minus infinity
        prod_d  = prod_q + (ge_q ? '0 : ems_pkg::RND_NEG);
        state_d = ems_pkg::ST_UPD;
      end
      ems_pkg::ST_UPD: begin
        avg_d      = ge_q ? (avg_q + inc) : (avg_q - inc);
        res_data_d = avg_d;
        res_rdy_d  = 1'b1;
        state_d    = ems_pkg::ST_DONE;
      end
      ems_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_data_q;
          out_user_d  = res_rdy_q;
          state_d     = ems_pkg::ST_IDLE;
        end
      end
      default: state_d = ems_pkg::ST_IDLE;
    endcase
  end

  // control and series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ems_pkg::ST_IDLE;
      period_q    <= ems_pkg::PERIOD_RST;
      alpha_q_q   <= ems_pkg::ALPHA_RST;
      cnt_q       <= '0;
      sum_q       <= '0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      period_q    <= period_d;
      alpha_q_q   <= alpha_q_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      avg_q       <= avg_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  // datapath shift registers and result payload
  always_ff @(posedge clk_i) begin
    dq_q       <= dq_d;
    rem_q      <= rem_d;
    prod_q     <= prod_d;
    diff_q     <= diff_d;
    ge_q       <= ge_d;
    res_data_q <= res_data_d;
    res_rdy_q  <= res_rdy_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;

endmodule

[rtl/ems_checker.sv]
module ems_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [ems_pkg::PRICE_W-1:0] m_axis_tdata,
  input logic [0:0]                  m_axis_tuser
);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a taken request keeps the input closed while it is worked on
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open right after a request");

  // a new result only appears after a busy cycle
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without work");

  // padding results carry a zero average
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("padding result not zero");

endmodule

bind ema_seeded_by_sma ems_checker u_ems_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[test/tb_ema_seeded_by_sma.sv]
module tb_ema_seeded_by_sma;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned LOG_CAP     = 40;

  // one sample request and one expected result
  typedef struct packed {
    logic [ems_pkg::PRICE_W-1:0] price;
    logic                        first;
  } sample_t;

  typedef struct packed {
    logic [ems_pkg::PRICE_W-1:0] value;
    logic                        ready;
  } average_t;

  // predictor of the smoothed price plus the queue of expected averages
  class ema_tracker;
    logic [ems_pkg::CNT_W-1:0]   period_r;
    logic [ems_pkg::ALPHA_W-1:0] alpha_r;
    logic [ems_pkg::CNT_W-1:0]   count_r;
    logic [ems_pkg::SUM_W-1:0]   sum_r;
    logic [ems_pkg::PRICE_W-1:0] avg_r;
    average_t                    expected_avgs[$];
    int                          errors;
    int                          results_seen;

    function new();
      period_r     = ems_pkg::PERIOD_RST;
      alpha_r      = ems_pkg::ALPHA_RST;
      count_r      = '0;
      sum_r        = '0;
      avg_r        = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(ems_pkg::cfg_idx_e idx, logic [ems_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ems_pkg::CFG_PERIOD: period_r = data[ems_pkg::CNT_W-1:0];
        ems_pkg::CFG_ALPHA:  alpha_r  = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_avgs.size();
    endfunction

    // advance the series by one accepted sample and queue its result
    function void note_sample(logic [ems_pkg::PRICE_W-1:0] price, logic first);
      logic [ems_pkg::CNT_W-1:0] span;
      logic [63:0]               gain;
      logic [63:0]               step;
      average_t                  want;
      span = period_r;
      if (span == '0) span = ems_pkg::CNT_W'(1);
      if (span > ems_pkg::MAX_PERIOD_DEF) span = ems_pkg::CNT_W'(ems_pkg::MAX_PERIOD_DEF);
      gain = (alpha_r > ems_pkg::ALPHA_ONE) ? 64'(ems_pkg::ALPHA_ONE) : 64'(alpha_r);
      if (first) begin
        count_r = '0;
        sum_r   = '0;
      end
      if (count_r < span) begin
        // warm-up: accumulate, seed once the count reaches the period
        sum_r   = sum_r + ems_pkg::SUM_W'(price);
        count_r = count_r + 1'b1;
        if (count_r >= span) begin
          avg_r      = ems_pkg::PRICE_W'(64'(sum_r) / 64'(span));
          want.value = avg_r;
          want.ready = 1'b1;
        end else begin
          want = '0;
        end
      end else begin
        // smoothing step, floor of a signed shift
        if (price >= avg_r) begin
          step  = (gain * 64'(price - avg_r)) >> 16;
          avg_r = avg_r + ems_pkg::PRICE_W'(step);
        end else begin
          step  = (gain * 64'(avg_r - price) + 64'd65535) >> 16;
          avg_r = avg_r - ems_pkg::PRICE_W'(step);
        end
        want.value = avg_r;
        want.ready = 1'b1;
      end
      expected_avgs = {expected_avgs, want};
    endfunction

    // keep the log short, every mismatch is still counted
    task report(string what);
      errors++;
      if (errors <= LOG_CAP) $display("%0t ns mismatch: %s", $time, what);
    endtask

    task check_result(logic [ems_pkg::PRICE_W-1:0] smoothed, logic ready);
      average_t want;
      results_seen++;
      if (expected_avgs.size() == 0) begin
        report($sformatf("result %0d (%h/%b) with no request pending",
                         results_seen, smoothed, ready));
        return;
      end
      want = expected_avgs.pop_front();
      if (smoothed !== want.value)
        report($sformatf("result %0d smoothed %h, expected %h",
                         results_seen, smoothed, want.value));
      if (ready !== want.ready)
        report($sformatf("result %0d ready %b, expected %b",
                         results_seen, ready, want.ready));
    endtask
  endclass

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [ems_pkg::PRICE_W-1:0]    s_axis_tdata  = '0;
  logic [0:0]                     s_axis_tuser  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [ems_pkg::PRICE_W-1:0]    m_axis_tdata;
  logic [0:0]                     m_axis_tuser;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [ems_pkg::CFG_IDX_W-1:0]  cfg_index_i   = ems_pkg::CFG_PERIOD;
  logic [ems_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  ema_tracker                  tracker;
  sample_t                     stim_q[$];
  logic [ems_pkg::PRICE_W-1:0] walk_price = 32'h0064_0000;
  bit                          src_quiet  = 1'b0;
  bit                          snk_quiet  = 1'b0;
  int unsigned                 cycle_count = 0;

  ema_seeded_by_sma dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : int'($urandom_range(16, 0));
  endfunction

  function automatic int eff_span(logic [ems_pkg::CNT_W-1:0] per);
    if (per == '0) return 1;
    if (per > ems_pkg::MAX_PERIOD_DEF) return ems_pkg::MAX_PERIOD_DEF;
    return int'(per);
  endfunction

  // alpha as software loads it, round(2/(span+1)) in Q1.16
  function automatic logic [ems_pkg::CFG_DATA_W-1:0] smoothing_alpha(int span);
    return ems_pkg::CFG_DATA_W'((131072 + (span + 1) / 2) / (span + 1));
  endfunction

  // mostly a random walk, now and then a jump or an extreme
  function automatic logic [ems_pkg::PRICE_W-1:0] next_price();
    int delta;
    case ($urandom_range(9, 0))
      0: walk_price = '0;
      1: walk_price = '1;
      2, 3: walk_price = $urandom;
      default: begin
        delta      = int'($urandom_range(2097152, 0)) - 1048576;
        walk_price = walk_price + ems_pkg::PRICE_W'(delta);
      end
    endcase
    return walk_price;
  endfunction

  function automatic void push_sample(logic [ems_pkg::PRICE_W-1:0] price, logic first);
    sample_t item;
    item.price = price;
    item.first = first;
    stim_q = {stim_q, item};
  endfunction

  // send queued sample requests, valid stays high across back-to-back requests
  task automatic flush_samples();
    sample_t item;
    int      gap;
    while (stim_q.size() != 0) begin
      item = stim_q.pop_front();
      gap  = draw_wait(src_quiet);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= item.price;
      s_axis_tuser  <= item.first;
      do @(posedge clk_i); while (!s_axis_tready);
      tracker.note_sample(item.price, item.first);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // write period then alpha, valid held between the two requests
  task automatic program_regs(logic [ems_pkg::CFG_DATA_W-1:0] per_word,
                              logic [ems_pkg::CFG_DATA_W-1:0] gain);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ems_pkg::CFG_PERIOD;
    cfg_data_i  <= per_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(ems_pkg::CFG_PERIOD, per_word);
    cfg_index_i <= ems_pkg::CFG_ALPHA;
    cfg_data_i  <= gain;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(ems_pkg::CFG_ALPHA, gain);
    cfg_valid_i <= 1'b0;
  endtask

  // one random setting, then series of random length with stray breaks
  task automatic run_random_phase(int n_items);
    logic [ems_pkg::CNT_W-1:0]      per;
    logic [ems_pkg::CFG_DATA_W-1:0] per_word;
    logic [ems_pkg::CFG_DATA_W-1:0] gain;
    int                             span;
    int                             len;
    int                             queued;
    bit                             mark;
    case ($urandom_range(9, 0))
      0: per = '0;
      1: per = ems_pkg::CNT_W'(1);
      2: per = ems_pkg::CNT_W'(ems_pkg::MAX_PERIOD_DEF);
      3: per = ems_pkg::CNT_W'($urandom_range(2047, ems_pkg::MAX_PERIOD_DEF + 1));
      default: per = ems_pkg::CNT_W'($urandom_range(16, 2));
    endcase
    per_word = {(ems_pkg::CFG_DATA_W - ems_pkg::CNT_W)'($urandom), per};
    span     = eff_span(per);
    case ($urandom_range(5, 0))
      0: gain = '0;
      1: gain = ems_pkg::ALPHA_ONE;
      2: gain = ems_pkg::CFG_DATA_W'($urandom_range(131071, 65537));
      3: gain = ems_pkg::CFG_DATA_W'($urandom);
      default: gain = smoothing_alpha(span);
    endcase
    wait_drained();
    program_regs(per_word, gain);
    src_quiet = ($urandom_range(3, 0) == 0);
    snk_quiet = ($urandom_range(3, 0) == 0);
    queued = 0;
    while (queued < n_items) begin
      if ($urandom_range(5, 0) == 0)
        len = (span > 1) ? int'($urandom_range(span - 1, 1)) : 1;
      else
        len = span + int'($urandom_range(2 * span + 8, 0));
      if (len > n_items - queued) len = n_items - queued;
      mark = ($urandom_range(7, 0) != 0);
      for (int i = 0; i < len; i++)
        push_sample(next_price(), (mark && i == 0) || ($urandom_range(31, 0) == 0));
      queued += len;
    end
    flush_samples();
  endtask

  // result side, stalls drawn per result
  initial begin : result_sink
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(snk_quiet);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_result(m_axis_tdata, m_axis_tuser[0]);
    end
  end

  // stimulus
  initial begin
    tracker = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting, series opened by reset, seed at mid scale then both directions
    for (int i = 0; i < 7; i++) push_sample(32'hFFFF_FFFF, 1'b0);
    for (int i = 0; i < 7; i++) push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    flush_samples();

    // period zero with upper data bits set, alpha zero keeps the seed
    wait_drained();
    program_regs(17'h1F800, '0);
    push_sample(32'h1234_5678, 1'b1);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    flush_samples();

    // alpha above one follows the price, then short series
    wait_drained();
    program_regs(17'd2, 17'h1FFFF);
    push_sample(32'hFFFF_FFFF, 1'b1);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'hABCD_EF01, 1'b1);
    push_sample(32'h0000_0001, 1'b1);
    flush_samples();

    // random settings and series, period changes land mid-series
    for (int ph = 0; ph < 9; ph++) run_random_phase(40);

    // period above the bound acts as the bound, short series stays padding
    wait_drained();
    program_regs({6'h3F, 11'h7FF}, 17'd128);
    push_sample(32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 7; i++) push_sample(next_price(), 1'b0);
    flush_samples();

    // lower the period under the count, smoothing goes on
    wait_drained();
    program_regs(17'd3, smoothing_alpha(3));
    for (int i = 0; i < 6; i++) push_sample(next_price(), 1'b0);
    flush_samples();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
